// File: rtl/escape_byte_rle_encoder_top_assert.svh
// Assertion macros for the escape-byte run-length encoder.
// Included by escape_byte_rle_encoder_top.sv; needs no other file.
`ifndef ESCAPE_BYTE_RLE_ENCODER_TOP_ASSERT_SVH
`define ESCAPE_BYTE_RLE_ENCODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Condition that holds at every clock edge outside reset.
`define EBRLE_ASSERT(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Consequence that holds in the same cycle as the antecedent.
`define EBRLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Consequence that holds in the cycle after the antecedent.
`define EBRLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define EBRLE_ASSERT(lbl, clk, rst_n, cond, msg)
`define EBRLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define EBRLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/ebrle_pkg.sv
// Shared constants, types and run emission functions of the escape-byte RLE encoder.
// No dependencies; used by the channel interfaces and the top level.
package ebrle_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned CFG_IDX_W   = 1;
	localparam int unsigned MAX_RESULTS = 4;
	localparam int unsigned SLOT_W      = $clog2(MAX_RESULTS + 1);

	// Result queue; the depth must be a power of two so the pointers wrap freely.
	localparam int unsigned FIFO_DEPTH = 8;
	localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_CODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONGEST_RUN = 1'b1;

	localparam logic [BYTE_W-1:0] ESCAPE_RESET  = 8'd255;
	localparam logic [BYTE_W-1:0] LONGEST_RESET = 8'd254;
	// Runs up to this length go out as literals, longer ones as a triple.
	localparam logic [BYTE_W-1:0] SHORT_RUN_MAX = 8'd3;

	typedef struct packed {
		logic [2:0][BYTE_W-1:0] bytes;
		logic [1:0]             cnt;
	} run_emit_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              item_done;
		logic              stream_done;
	} out_entry_t;

	// Bytes that a finished run of the given length produces.
	function automatic run_emit_t run_emit(input logic [BYTE_W-1:0] value,
			input logic [BYTE_W-1:0] length, input logic [BYTE_W-1:0] esc);
		run_emit_t r;
		r.bytes = {3{value}};
		r.cnt   = 2'd0;
		if (length == '0) begin
			r.cnt = 2'd0;
		end else if (length <= SHORT_RUN_MAX) begin
			r.cnt = length[1:0];
		end else begin
			r.bytes[0] = esc;
			r.bytes[1] = value;
			r.bytes[2] = length;
			r.cnt      = 2'd3;
		end
		return r;
	endfunction

	// Picks one byte of a run emission; the unused fourth code reads as zero.
	function automatic logic [BYTE_W-1:0] pick_byte(input run_emit_t r, input logic [1:0] idx);
		logic [BYTE_W-1:0] b;
		b = '0;
		if (idx != 2'd3) begin
			b = r.bytes[idx];
		end
		return b;
	endfunction

endpackage

// File: rtl/ebrle_stream_if.sv
// Valid/ready channel interfaces for the escape-byte RLE encoder.
// Depends on ebrle_pkg for the byte width.
interface ebrle_in_if import ebrle_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface ebrle_out_if import ebrle_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              item_done;
	logic              stream_done;

	modport source (output valid, output out_byte, output item_done, output stream_done,
		input ready);
	modport sink (input valid, input out_byte, input item_done, input stream_done,
		output ready);
endinterface

// File: rtl/escape_byte_rle_encoder_top.sv
// Escape-byte run-length encoder, top level.
// Depends on ebrle_pkg, ebrle_stream_if.sv and escape_byte_rle_encoder_top_assert.svh.
//
// The encoder takes one raw byte per request on in_ch and writes the compressed
// stream, one byte per request, on out_ch. A run of one to three equal bytes goes
// out as literal bytes; a run of four or more goes out as the escape code, the
// byte value and the run length. A run is closed when a different byte arrives,
// when it reaches longest_run bytes, or when a request with final_byte set has been
// taken in; that last case flushes the pending run and the next byte starts a new
// buffer. Literal bytes equal to the escape code are sent unchanged. On every
// result, item_done marks the last byte caused by one input request, and
// stream_done marks the last compressed byte of a buffer. A request that only
// starts or extends a run produces no result at all.
// Timing: an input request is registered in the input stage, and once the queue has
// room one pass of logic updates the run state and pushes zero to four result bytes
// into an eight-entry result queue, from which out_ch is driven. The input side takes
// one request per clock as long as the queue can hold four more bytes after this
// cycle's read. A result is valid on out_ch once it has been written into the queue.
// The output side drains one byte per cycle while out_ch.ready is high, so requests
// that emit several bytes throttle the input through the queue occupancy.
// Configuration (escape_code at index 0, longest_run at index 1) is written through
// cfg_we, cfg_index and cfg_wdata and must only change while the encoder is idle.
`include "escape_byte_rle_encoder_top_assert.svh"

module escape_byte_rle_encoder_top import ebrle_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_wdata,
	ebrle_in_if.sink             in_ch,
	ebrle_out_if.source          out_ch
);

	// Configuration registers.
	logic [BYTE_W-1:0] escape_code_q;
	logic [BYTE_W-1:0] longest_run_q;

	// Run state: the byte of the pending run and its length, zero for no run.
	logic [BYTE_W-1:0] run_value_q;
	logic [BYTE_W-1:0] run_length_q;

	// Input register stage.
	logic              valid_s1;
	logic [BYTE_W-1:0] data_byte_s1;
	logic              final_byte_s1;

	// Result queue.
	out_entry_t            fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	logic                  in_accept;
	logic                  pop;
	logic                  advance;
	logic [FIFO_CNT_W-1:0] occ_after_pop;

	// Encoding pass.
	logic              extend;
	logic [BYTE_W-1:0] len_new;
	logic              close_run;
	run_emit_t         first_emit;
	run_emit_t         second_emit;
	logic [SLOT_W-1:0] n_first;
	logic [SLOT_W-1:0] n_total;
	out_entry_t        slot [MAX_RESULTS];

	// The stage advances only when the queue is sure to hold the largest burst.
	assign pop           = out_ch.valid && out_ch.ready;
	assign occ_after_pop = count_q - FIFO_CNT_W'(pop);
	assign advance       = valid_s1 &&
		(occ_after_pop <= FIFO_CNT_W'(FIFO_DEPTH - MAX_RESULTS));
	assign in_ch.ready   = !valid_s1 || advance;
	assign in_accept     = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_code_q <= ESCAPE_RESET;
			longest_run_q <= LONGEST_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ESCAPE_CODE: escape_code_q <= cfg_wdata;
				CFG_LONGEST_RUN: longest_run_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			data_byte_s1  <= in_ch.data_byte;
			final_byte_s1 <= in_ch.final_byte;
		end
	end

	// The incoming byte either extends the pending run or closes it and starts a
	// new one. The resulting run is closed at once when it hits the limit or when the
	// byte ends the buffer; both cases emit the same bytes, so one emission covers
	// them.
	always_comb begin
		extend      = (run_length_q != '0) && (data_byte_s1 == run_value_q);
		first_emit  = run_emit(run_value_q, extend ? '0 : run_length_q, escape_code_q);
		len_new     = extend ? run_length_q + 8'd1 : 8'd1;
		close_run   = (len_new >= longest_run_q) || final_byte_s1;
		second_emit = run_emit(data_byte_s1, close_run ? len_new : '0, escape_code_q);
		n_first     = SLOT_W'(first_emit.cnt);
		n_total     = n_first + SLOT_W'(second_emit.cnt);
	end

	// Lay the two emissions side by side in the result slots.
	always_comb begin
		for (int k = 0; k < MAX_RESULTS; k++) begin
			if (SLOT_W'(k) < n_first) begin
				slot[k].out_byte = pick_byte(first_emit, 2'(k));
			end else begin
				slot[k].out_byte = pick_byte(second_emit, 2'(k - int'(n_first)));
			end
			slot[k].item_done   = (SLOT_W'(k) == n_total - SLOT_W'(1));
			slot[k].stream_done = (SLOT_W'(k) == n_total - SLOT_W'(1)) && final_byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_value_q  <= '0;
			run_length_q <= '0;
		end else if (advance) begin
			run_value_q  <= data_byte_s1;
			run_length_q <= close_run ? '0 : len_new;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int k = 0; k < MAX_RESULTS; k++) begin
				if (SLOT_W'(k) < n_total) begin
					fifo_q[wr_ptr_q + FIFO_PTR_W'(k)] <= slot[k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			if (advance) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(n_total);
				count_q  <= occ_after_pop + FIFO_CNT_W'(n_total);
			end else begin
				count_q  <= occ_after_pop;
			end
		end
	end

	assign out_ch.valid       = (count_q != '0);
	assign out_ch.out_byte    = fifo_q[rd_ptr_q].out_byte;
	assign out_ch.item_done   = fifo_q[rd_ptr_q].item_done;
	assign out_ch.stream_done = fifo_q[rd_ptr_q].stream_done;

	`EBRLE_ASSERT(a_queue_bound, clk, arst_n, count_q <= FIFO_CNT_W'(FIFO_DEPTH), "result queue overflow")
	`EBRLE_ASSERT_NXT(a_final_flush, clk, arst_n, advance && final_byte_s1, run_length_q == '0, "run left pending after final byte")
	`EBRLE_ASSERT_IMP(a_stream_done_last, clk, arst_n, out_ch.valid && out_ch.stream_done, out_ch.item_done, "stream_done without item_done")

endmodule
